// ===== src/magnetic_dipole_field_defines.svh =====
// Assertion macros shared by the magnetic dipole field block.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef MAGNETIC_DIPOLE_FIELD_DEFINES_SVH
`define MAGNETIC_DIPOLE_FIELD_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define MDF_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off during reset.
`define MDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mdf_pkg.sv =====
// Shared types, constants and helper functions of the magnetic dipole field block.
// No dependencies; used by every module of the block.
package mdf_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int MOM_W          = 16;
	localparam int GAIN_W         = 63;
	localparam int OUT_W          = 32;
	localparam int Q_BITS         = 33;
	localparam int K_SHIFT        = 28;
	localparam int MUL_DIG        = 16;
	localparam int LANES          = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam logic [MOM_W-1:0] MOMENT_Z_RST = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGNET_X   = 3'd0,
		REG_MAGNET_Y   = 3'd1,
		REG_MAGNET_Z   = 3'd2,
		REG_MOMENT_X   = 3'd3,
		REG_MOMENT_Y   = 3'd4,
		REG_MOMENT_Z   = 3'd5,
		REG_FIELD_GAIN = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_AT_MAGNET = 2'd1,
		ST_SAT       = 2'd2
	} status_t;

	typedef struct packed {
		logic zero;
		logic neg;
	} lane_side_t;

	// Number of digit stages a multiplier needs for a multiplicand of bw bits.
	function automatic int mul_stages(input int bw);
		return (bw + MUL_DIG - 1) / MUL_DIG;
	endfunction

endpackage

// ===== src/magnetic_dipole_field.sv =====
// An accepted item passes the front-end stages, then the longer of the denominator path
// and the numerator lanes, then the root search and the output register; at the default
// COORD_BITS of 20 the numerator lanes are the longer path.
// Throughput: one item per cycle; the whole pipeline advances whenever the output register
// is empty or its result is being taken, so a stall holds every stage in place.
// Reset clears all stage valid flags and loads the configuration registers with their
// documented reset values; there are no memories and no clearing pass.
//
// Point-dipole field model. Depends on mdf_pkg, mdf_mul, mdf_sqrt and the defines header.
`include "magnetic_dipole_field_defines.svh"

module magnetic_dipole_field #(
	parameter int COORD_BITS = mdf_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items: sensor_x, sensor_y, sensor_z from bit 0 up, zero filled to bytes.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// Result items: field_x, field_y, field_z from bit 0 up.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [3*mdf_pkg::OUT_W-1:0]       m_axis_tdata,
	// Result status: status (0 ok, 1 sensor at magnet, 2 saturated).
	output logic [1:0]                        m_axis_tuser,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mdf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int NL   = mdf_pkg::LANES;
	localparam int MW   = mdf_pkg::MOM_W;
	localparam int GW   = mdf_pkg::GAIN_W;
	localparam int OW   = mdf_pkg::OUT_W;
	localparam int QB   = mdf_pkg::Q_BITS;
	localparam int RW   = COORD_BITS + 1;         // sensor minus magnet
	localparam int SQW  = 2 * RW;                 // one squared offset
	localparam int SW   = 2 * RW + 2;             // |r|^2
	localparam int MRW  = MW + RW;                // one moment times offset product
	localparam int TW   = MRW + 4;                // 3 (m.r)
	localparam int P1W  = TW + RW;
	localparam int P2W  = SW + MW + 1;
	localparam int NW   = ((P1W > P2W) ? P1W : P2W) + 1;
	localparam int GNW  = GW + NW;
	localparam int AW   = 2 * GNW;
	localparam int S2W  = 2 * SW;
	localparam int S4W  = 4 * SW;
	localparam int S5W  = 5 * SW;
	localparam int KW   = S5W + mdf_pkg::K_SHIFT;

	// The denominator path leaves the third stage and the numerator lanes the fifth; the
	// shorter one gets idle stages on its last multiplier so both meet at the root search.
	localparam int LK   = mdf_pkg::mul_stages(SW) + mdf_pkg::mul_stages(S2W)
		+ mdf_pkg::mul_stages(SW);
	localparam int LA   = mdf_pkg::mul_stages(NW) + mdf_pkg::mul_stages(GNW);
	localparam int KEND = 3 + LK;
	localparam int AEND = 5 + LA;
	localparam int KPAD = (AEND > KEND) ? AEND - KEND : 0;
	localparam int APAD = (KEND > AEND) ? KEND - AEND : 0;

	localparam logic [QB-1:0] NEG_LIM = QB'(1) << (OW - 1);
	localparam logic [QB-1:0] POS_LIM = NEG_LIM - QB'(1);
	localparam logic [OW-1:0] FMAX    = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] FMIN    = {1'b1, {(OW-1){1'b0}}};

	// Configuration registers, to be written only while the pipeline is empty; unenforced.
	logic signed [COORD_BITS-1:0] mag_q [NL];
	logic signed [MW-1:0]         mom_q [NL];
	logic [GW-1:0]                gain_q;

	logic en;

	// Stage registers of the front end.
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [RW-1:0]  r_s1  [NL];
	logic signed [RW-1:0]  r_s2  [NL];
	logic signed [RW-1:0]  r_s3  [NL];
	logic [SQW-1:0]        sq_s2 [NL];
	logic signed [MRW-1:0] mr_s2 [NL];
	logic [SW-1:0]         s_s3;
	logic                  zero_s3;
	logic signed [TW-1:0]  t_s3;
	logic signed [P1W-1:0] p1_s4 [NL];
	logic signed [P2W-1:0] p2_s4 [NL];
	logic [NW-1:0]         nmag_s5 [NL];
	logic [NL-1:0]         neg_s5;

	logic [SW-1:0]         s_sum;
	logic signed [TW-1:0]  t_sum;

	// Denominator path.
	logic                  k1_v, k2_v, k_v;
	logic [S2W-1:0]        k1_p;
	logic [S4W-1:0]        k2_p;
	logic [S5W-1:0]        s5_p;
	logic [SW:0]           k1_sd, k2_sd;
	logic                  k_zero;

	// Numerator lanes.
	logic [NL-1:0]         gv, av, gneg, aneg;
	logic [GNW-1:0]        gn_p  [NL];
	logic [AW-1:0]         a_p   [NL];
	mdf_pkg::lane_side_t   sq_side_i [NL];

	// Root search results.
	logic                  rt_v;
	logic [QB-1:0]         rt_q    [NL];
	mdf_pkg::lane_side_t   rt_side [NL];

	// Output register.
	logic                  out_vld_q;
	logic [OW-1:0]         out_f_q [NL];
	mdf_pkg::status_t      out_status_q;
	logic [OW-1:0]         fld_nx  [NL];
	logic [NL-1:0]         sat_nx;
	mdf_pkg::status_t      status_nx;

	// The pipeline moves as one; the output register is its last stage, so a new item is
	// taken in the same cycle that a finished result leaves.
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// Configuration writes; an index past the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				mag_q[i] <= '0;
			end
			mom_q[0] <= '0;
			mom_q[1] <= '0;
			mom_q[2] <= mdf_pkg::MOMENT_Z_RST;
			gain_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (mdf_pkg::reg_idx_t'(cfg_index))
				mdf_pkg::REG_MAGNET_X:   mag_q[0] <= cfg_data[COORD_BITS-1:0];
				mdf_pkg::REG_MAGNET_Y:   mag_q[1] <= cfg_data[COORD_BITS-1:0];
				mdf_pkg::REG_MAGNET_Z:   mag_q[2] <= cfg_data[COORD_BITS-1:0];
				mdf_pkg::REG_MOMENT_X:   mom_q[0] <= cfg_data[MW-1:0];
				mdf_pkg::REG_MOMENT_Y:   mom_q[1] <= cfg_data[MW-1:0];
				mdf_pkg::REG_MOMENT_Z:   mom_q[2] <= cfg_data[MW-1:0];
				mdf_pkg::REG_FIELD_GAIN: gain_q   <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// Valid flags of the front-end stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage three sums: |r|^2 and three times the moment dot offset.
	always_comb begin
		s_sum = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		t_sum = TW'(mr_s2[0]) + TW'(mr_s2[1]) + TW'(mr_s2[2]);
	end

	// Front end: offset, squares and moment products, sums, numerator terms, numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				r_s1[i]  <= RW'($signed(s_axis_tdata[i*COORD_BITS +: COORD_BITS]))
					- RW'(mag_q[i]);
				sq_s2[i] <= SQW'(SQW'(r_s1[i]) * SQW'(r_s1[i]));
				mr_s2[i] <= MRW'(mom_q[i]) * MRW'(r_s1[i]);
				r_s2[i]  <= r_s1[i];
				r_s3[i]  <= r_s2[i];
				p1_s4[i] <= P1W'(t_s3) * P1W'(r_s3[i]);
				p2_s4[i] <= P2W'($signed({1'b0, s_s3})) * P2W'(mom_q[i]);
				if (NW'(p1_s4[i]) < NW'(p2_s4[i])) begin
					nmag_s5[i] <= NW'(p2_s4[i]) - NW'(p1_s4[i]);
					neg_s5[i]  <= 1'b1;
				end else begin
					nmag_s5[i] <= NW'(p1_s4[i]) - NW'(p2_s4[i]);
					neg_s5[i]  <= 1'b0;
				end
			end
			s_s3    <= s_sum;
			zero_s3 <= (s_sum == '0);
			t_s3    <= (t_sum <<< 1) + t_sum;
		end
	end

	// Denominator: s^2, s^4, s^5. The sensor-at-magnet flag rides along with it.
	mdf_mul #(.AW(SW), .BW(SW), .PW(SW + 1), .NS(mdf_pkg::mul_stages(SW))) u_k1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s3), .a(s_s3), .b(s_s3), .side_i({zero_s3, s_s3}),
		.vld_o(k1_v), .p(k1_p), .side_o(k1_sd)
	);

	mdf_mul #(.AW(S2W), .BW(S2W), .PW(SW + 1), .NS(mdf_pkg::mul_stages(S2W))) u_k2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(k1_v), .a(k1_p), .b(k1_p), .side_i(k1_sd),
		.vld_o(k2_v), .p(k2_p), .side_o(k2_sd)
	);

	mdf_mul #(.AW(S4W), .BW(SW), .PW(1), .NS(mdf_pkg::mul_stages(SW) + KPAD)) u_k3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(k2_v), .a(k2_p), .b(k2_sd[SW-1:0]), .side_i(k2_sd[SW]),
		.vld_o(k_v), .p(s5_p), .side_o(k_zero)
	);

	// Numerator lanes: gain times |n|, then squared so the root search stays in integers.
	for (genvar l = 0; l < NL; l++) begin : g_lane
		mdf_mul #(.AW(GW), .BW(NW), .PW(1), .NS(mdf_pkg::mul_stages(NW))) u_gain (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(vld_s5), .a(gain_q), .b(nmag_s5[l]), .side_i(neg_s5[l]),
			.vld_o(gv[l]), .p(gn_p[l]), .side_o(gneg[l])
		);

		mdf_mul #(.AW(GNW), .BW(GNW), .PW(1), .NS(mdf_pkg::mul_stages(GNW) + APAD)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(gv[l]), .a(gn_p[l]), .b(gn_p[l]), .side_i(gneg[l]),
			.vld_o(av[l]), .p(a_p[l]), .side_o(aneg[l])
		);

		assign sq_side_i[l] = '{zero: k_zero, neg: aneg[l]};
	end

	// Largest q with q^2 * 2^28 * s^5 <= (gain * n)^2, one bit per stage.
	mdf_sqrt #(.AW(AW), .KW(KW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(av[0]), .rem_i(a_p), .k_i(KW'(s5_p) << mdf_pkg::K_SHIFT),
		.side_i(sq_side_i),
		.vld_o(rt_v), .q_o(rt_q), .side_o(rt_side)
	);

	// Sign, saturation and status of the finished item.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (rt_side[l].neg) begin
				sat_nx[l] = (rt_q[l] > NEG_LIM);
				fld_nx[l] = OW'(QB'(0) - (sat_nx[l] ? NEG_LIM : rt_q[l]));
			end else begin
				sat_nx[l] = (rt_q[l] > POS_LIM);
				fld_nx[l] = OW'(sat_nx[l] ? POS_LIM : rt_q[l]);
			end
		end
		if (rt_side[0].zero) begin
			status_nx = mdf_pkg::ST_AT_MAGNET;
			for (int l = 0; l < NL; l++) begin
				fld_nx[l] = '0;
			end
		end else if (|sat_nx) begin
			status_nx = mdf_pkg::ST_SAT;
		end else begin
			status_nx = mdf_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				out_f_q[l] <= fld_nx[l];
			end
			out_status_q <= status_nx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_f_q[2], out_f_q[1], out_f_q[0]};
	assign m_axis_tuser  = out_status_q;

	// The denominator and the three numerator lanes must reach the root search together.
	`MDF_ASSERT(a_path_align, k_v || av[0] || av[1] || av[2], k_v && av[0] && av[1] && av[2], "denominator and numerator paths out of step")
	// A sensor at the magnet gives an all-zero field.
	`MDF_ASSERT(a_magnet_zero, m_axis_tvalid && (m_axis_tuser == mdf_pkg::ST_AT_MAGNET), m_axis_tdata == '0, "sensor at magnet with non-zero field")
	// A saturated result carries at least one component at a limit.
	`MDF_ASSERT(a_sat_limit, m_axis_tvalid && (m_axis_tuser == mdf_pkg::ST_SAT), (out_f_q[0] == FMAX) || (out_f_q[0] == FMIN) || (out_f_q[1] == FMAX) || (out_f_q[1] == FMIN) || (out_f_q[2] == FMAX) || (out_f_q[2] == FMIN), "saturation status without a limited component")

endmodule

// ===== src/mdf_mul.sv =====
// Pipelined unsigned multiplier, one 16-bit digit of b per stage, with a sideband.
// Depends on mdf_pkg.
module mdf_mul #(
	parameter int AW = 16,
	parameter int BW = 16,
	parameter int PW = 1,
	parameter int NS = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  logic [AW-1:0]        a,
	input  logic [BW-1:0]        b,
	input  logic [PW-1:0]        side_i,
	output logic                 vld_o,
	output logic [AW+BW-1:0]     p,
	output logic [PW-1:0]        side_o
);

	localparam int DIG = mdf_pkg::MUL_DIG;
	localparam int BPW = NS * DIG;
	localparam int PRW = AW + BW;

	logic [NS-1:0]  vld_s;
	logic [AW-1:0]  a_s    [NS];
	logic [BPW-1:0] b_s    [NS];
	logic [PRW-1:0] acc_s  [NS];
	logic [PW-1:0]  side_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stg
		logic           v_in;
		logic [AW-1:0]  a_in;
		logic [BPW-1:0] b_in;
		logic [PRW-1:0] acc_in;
		logic [PW-1:0]  sd_in;
		logic [AW+DIG-1:0] pp;

		if (j == 0) begin : g_first
			assign v_in   = vld_i;
			assign a_in   = a;
			assign b_in   = BPW'(b);
			assign acc_in = '0;
			assign sd_in  = side_i;
		end else begin : g_next
			assign v_in   = vld_s[j-1];
			assign a_in   = a_s[j-1];
			assign b_in   = b_s[j-1];
			assign acc_in = acc_s[j-1];
			assign sd_in  = side_s[j-1];
		end

		assign pp = (AW+DIG)'(a_in) * (AW+DIG)'(b_in[DIG*j +: DIG]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[j]    <= a_in;
				b_s[j]    <= b_in;
				acc_s[j]  <= acc_in + (PRW'(pp) << (DIG * j));
				side_s[j] <= sd_in;
			end
		end
	end

	assign vld_o  = vld_s[NS-1];
	assign p      = acc_s[NS-1];
	assign side_o = side_s[NS-1];

endmodule

// ===== src/mdf_sqrt.sv =====
// Bit-per-stage search for the largest q with q*q*k <= a, on three lanes sharing k.
// Depends on mdf_pkg.
module mdf_sqrt #(
	parameter int AW = 16,
	parameter int KW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [AW-1:0]              rem_i  [mdf_pkg::LANES],
	input  logic [KW-1:0]              k_i,
	input  mdf_pkg::lane_side_t        side_i [mdf_pkg::LANES],
	output logic                       vld_o,
	output logic [mdf_pkg::Q_BITS-1:0] q_o    [mdf_pkg::LANES],
	output mdf_pkg::lane_side_t        side_o [mdf_pkg::LANES]
);

	localparam int QB  = mdf_pkg::Q_BITS;
	localparam int NL  = mdf_pkg::LANES;
	localparam int QKW = KW + QB;
	localparam int EW  = ((AW > KW + 2 * QB) ? AW : KW + 2 * QB) + 1;

	logic [QB-1:0]       vld_s;
	logic [KW-1:0]       k_s    [QB];
	logic [AW-1:0]       rem_s  [QB][NL];
	logic [QKW-1:0]      qk_s   [QB][NL];
	logic [QB-1:0]       q_s    [QB][NL];
	mdf_pkg::lane_side_t side_s [QB][NL];

	for (genvar j = 0; j < QB; j++) begin : g_stg
		localparam int B = QB - 1 - j;

		logic                v_in;
		logic [KW-1:0]       k_in;
		logic [AW-1:0]       rem_in [NL];
		logic [QKW-1:0]      qk_in  [NL];
		logic [QB-1:0]       q_in   [NL];
		mdf_pkg::lane_side_t sd_in  [NL];
		logic [EW-1:0]       d      [NL];
		logic [NL-1:0]       ok;
		logic [AW-1:0]       rem_nx [NL];
		logic [QKW-1:0]      qk_nx  [NL];
		logic [QB-1:0]       q_nx   [NL];

		if (j == 0) begin : g_first
			assign v_in = vld_i;
			assign k_in = k_i;
			always_comb begin
				for (int l = 0; l < NL; l++) begin
					rem_in[l] = rem_i[l];
					qk_in[l]  = '0;
					q_in[l]   = '0;
					sd_in[l]  = side_i[l];
				end
			end
		end else begin : g_next
			assign v_in = vld_s[j-1];
			assign k_in = k_s[j-1];
			always_comb begin
				for (int l = 0; l < NL; l++) begin
					rem_in[l] = rem_s[j-1][l];
					qk_in[l]  = qk_s[j-1][l];
					q_in[l]   = q_s[j-1][l];
					sd_in[l]  = side_s[j-1][l];
				end
			end
		end

		// Setting bit B raises q*q*k by 2^(B+1)*q*k + 2^(2B)*k; take it when the remainder allows.
		always_comb begin
			for (int l = 0; l < NL; l++) begin
				d[l]      = (EW'(qk_in[l]) << (B + 1)) + (EW'(k_in) << (2 * B));
				ok[l]     = (d[l] <= EW'(rem_in[l]));
				rem_nx[l] = ok[l] ? AW'(EW'(rem_in[l]) - d[l]) : rem_in[l];
				qk_nx[l]  = ok[l] ? (qk_in[l] + (QKW'(k_in) << B)) : qk_in[l];
				q_nx[l]   = ok[l] ? (q_in[l] | (QB'(1) << B)) : q_in[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_s[j] <= k_in;
				for (int l = 0; l < NL; l++) begin
					rem_s[j][l]  <= rem_nx[l];
					qk_s[j][l]   <= qk_nx[l];
					q_s[j][l]    <= q_nx[l];
					side_s[j][l] <= sd_in[l];
				end
			end
		end
	end

	assign vld_o = vld_s[QB-1];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			q_o[l]    = q_s[QB-1][l];
			side_o[l] = side_s[QB-1][l];
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for magnetic_dipole_field: streams sensor positions under
// several magnet, moment and gain settings and checks every field result bit for bit.
// Depends on mdf_pkg and the magnetic_dipole_field RTL; reads no files.
`timescale 1ns / 100ps

module tb_top;
	import mdf_pkg::*;

	localparam int CB        = 20;
	localparam int LATENCY   = 51;
	localparam int DRAIN     = LATENCY + 20;
	localparam int MAX_CYC   = 400000;
	localparam int HOLD_LEN  = 400;
	// The index channel is three bits wide, so one code lies past the last register.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the configuration registers, kept up to date on every accepted write.
	logic signed [CB-1:0] magnet [3];
	logic signed [MOM_W-1:0] moment [3];
	logic [GAIN_W-1:0] gain;

	logic [59:0] pending_pos [$];	// sensor items waiting to be offered
	logic [97:0] field_expected [$];	// {status, field_z, field_y, field_x}
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_sat = 0;
	int n_at_magnet = 0;
	int cycles = 0;

	magnetic_dipole_field #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Exact dipole field for one sensor position. The wide products are carried in 320-bit
	// unsigned magnitudes, so the truncated square root below is exact: the largest q
	// with q^2 * 2^28 * s^5 <= (gain * N)^2, where N is the numerator of one component.
	function automatic logic [97:0] dipole_field(input logic [59:0] pos);
		longint r [3];
		longint m [3];
		longint t, ar, am, at;
		logic [319:0] s, k, t1, t2, nmag, a2, c;
		logic [31:0] f [3];
		status_t st;
		bit neg1, neg2, neg;
		longint unsigned q, cq;
		int i, b;
		s = '0;
		st = ST_OK;
		for (i = 0; i < 3; i++) begin
			r[i] = longint'($signed(pos[CB*i +: CB])) - longint'(magnet[i]);
			m[i] = longint'(moment[i]);
			ar = (r[i] < 0) ? -r[i] : r[i];
			s = s + 320'(ar) * 320'(ar);
		end
		if (s == 0)
			return {ST_AT_MAGNET, 96'd0};
		t = 3 * (m[0] * r[0] + m[1] * r[1] + m[2] * r[2]);
		at = (t < 0) ? -t : t;
		k = s * s;
		k = k * k;
		k = (k * s) << K_SHIFT;
		for (i = 0; i < 3; i++) begin
			ar = (r[i] < 0) ? -r[i] : r[i];
			am = (m[i] < 0) ? -m[i] : m[i];
			t1 = 320'(at) * 320'(ar);
			t2 = s * 320'(am);
			neg1 = (t < 0) != (r[i] < 0);
			neg2 = !(m[i] < 0);
			// The moment term enters with a minus sign, hence neg2 is set for a positive m.
			if (neg1 == neg2) begin
				nmag = t1 + t2;
				neg = neg1;
			end else if (t1 >= t2) begin
				nmag = t1 - t2;
				neg = neg1;
			end else begin
				nmag = t2 - t1;
				neg = neg2;
			end
			a2 = 320'(gain) * nmag;
			a2 = a2 * a2;
			q = 0;
			for (b = 32; b >= 0; b--) begin
				cq = q | (64'd1 << b);
				c = 320'(cq);
				if (k * c * c <= a2)
					q = cq;
			end
			if (neg) begin
				if (q > 64'h8000_0000) begin
					q = 64'h8000_0000;
					st = ST_SAT;
				end
				f[i] = 32'(64'd0 - q);
			end else begin
				if (q > 64'h7FFF_FFFF) begin
					q = 64'h7FFF_FFFF;
					st = ST_SAT;
				end
				f[i] = q[31:0];
			end
		end
		return {st, f[2], f[1], f[0]};
	endfunction

	// Sender: offers queued sensor items and records the expected field of each one taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				field_expected.push_back(dipole_field(s_axis_tdata[59:0]));
				n_items++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, pending_pos.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so that the sender keeps pushing meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: compares each result item with the oldest expectation, field by field.
	always @(posedge clk or negedge arst_n) begin
		logic [97:0] exp_item;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (field_expected.size() == 0) begin
					$display("%0t: unexpected result item %h status %0d", $time,
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					exp_item = field_expected.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (m_axis_tdata[32*i +: 32] !== exp_item[32*i +: 32]) begin
							$display("%0t: field component %0d expected %0d actual %0d",
								$time, i, $signed(exp_item[32*i +: 32]),
								$signed(m_axis_tdata[32*i +: 32]));
							errors++;
						end
					end
					if (m_axis_tuser !== exp_item[97:96]) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_item[97:96], m_axis_tuser);
						errors++;
					end
					if (exp_item[97:96] == ST_SAT)
						n_sat++;
					if (exp_item[97:96] == ST_AT_MAGNET)
						n_at_magnet++;
				end
			end
			m_axis_tready <= (hold_left != 0) ? 1'b0 : ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog against a hung pipeline or handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYC) begin
			$display("SCOREBOARD MISMATCH");
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				field_expected.size());
			$finish;
		end
	end

	// Writes one register and mirrors it; bits above the register width carry noise,
	// which the block must drop.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		logic [63:0] data;
		data = {$urandom, $urandom};
		case (idx)
			REG_MAGNET_X, REG_MAGNET_Y, REG_MAGNET_Z: data[CB-1:0] = value[CB-1:0];
			REG_MOMENT_X, REG_MOMENT_Y, REG_MOMENT_Z: data[15:0] = value[15:0];
			REG_FIELD_GAIN: data[62:0] = value[62:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAGNET_X: magnet[0] = data[CB-1:0];
			REG_MAGNET_Y: magnet[1] = data[CB-1:0];
			REG_MAGNET_Z: magnet[2] = data[CB-1:0];
			REG_MOMENT_X: moment[0] = data[15:0];
			REG_MOMENT_Y: moment[1] = data[15:0];
			REG_MOMENT_Z: moment[2] = data[15:0];
			REG_FIELD_GAIN: gain = data[62:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CB-1:0] mx, my, mz,
			input logic [15:0] ox, oy, oz, input logic [62:0] g);
		write_reg(REG_MAGNET_X, 64'(mx));
		write_reg(REG_MAGNET_Y, 64'(my));
		write_reg(REG_MAGNET_Z, 64'(mz));
		write_reg(REG_MOMENT_X, 64'(ox));
		write_reg(REG_MOMENT_Y, 64'(oy));
		write_reg(REG_MOMENT_Z, 64'(oz));
		write_reg(REG_FIELD_GAIN, 64'(g));
	endtask

	// Waits until every item has gone through and the pipeline has emptied.
	task automatic wait_idle;
		while (pending_pos.size() != 0 || s_axis_tvalid || field_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [59:0] pos3(input int x, y, z);
		logic [CB-1:0] px, py, pz;
		px = CB'(x);
		py = CB'(y);
		pz = CB'(z);
		return {pz, py, px};
	endfunction

	// Mostly positions near the magnet at a random scale, so that both ordinary and
	// saturated fields turn up; the rest spread over the whole coordinate range.
	task automatic queue_random(input int count);
		int sc;
		logic [CB-1:0] c [3];
		for (int n = 0; n < count; n++) begin
			sc = $urandom_range(CB - 1);
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(9) < 7)
					c[i] = magnet[i] + CB'($signed($urandom) >>> (31 - sc));
				else
					c[i] = CB'($urandom);
			end
			if ($urandom_range(49) == 0)
				c = '{magnet[0], magnet[1], magnet[2]};
			pending_pos.push_back({c[2], c[1], c[0]});
		end
	endtask

	function automatic logic [62:0] rand_gain;
		return 63'({$urandom, $urandom}) >> $urandom_range(62);
	endfunction

	function automatic logic [15:0] rand_moment;
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'(-16384);
			2: return 16'd16384;
			default: return 16'($signed(16'($urandom)) >>> 1);
		endcase
	endfunction

	initial begin
		magnet = '{default: '0};
		moment = '{16'd0, 16'd0, MOMENT_Z_RST};
		gain = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle = 32;
		recv_idle = 78;

		// Reset settings: zero gain gives zero fields everywhere; at the magnet the status says so.
		pending_pos.push_back(pos3(0, 0, 0));
		pending_pos.push_back(pos3(524287, 524287, 524287));
		pending_pos.push_back(pos3(-524288, -524288, -524288));
		pending_pos.push_back(pos3(524287, -524288, 1));
		pending_pos.push_back(pos3(0, 0, -1));
		wait_idle();

		// Magnet at the origin, moment along z: on-axis and off-axis points, with a gain
		// large enough to saturate close in, in both directions.
		set_config('0, '0, '0, 16'd0, 16'd0, 16'd16384, 63'd1 << 50);
		pending_pos.push_back(pos3(0, 0, 0));
		pending_pos.push_back(pos3(0, 0, 1));
		pending_pos.push_back(pos3(0, 0, -1));
		pending_pos.push_back(pos3(1, 0, 0));
		pending_pos.push_back(pos3(0, -1, 0));
		pending_pos.push_back(pos3(0, 0, 100000));
		pending_pos.push_back(pos3(100000, 0, 0));
		pending_pos.push_back(pos3(70000, -70000, 70000));
		pending_pos.push_back(pos3(524287, 524287, 524287));
		pending_pos.push_back(pos3(-524288, -524288, -524288));
		pending_pos.push_back(pos3(524287, -524288, 524287));
		wait_idle();

		// Extreme corner: magnet at the most negative position, the most extreme moments,
		// the largest gain, and a write to the spare index that must change nothing.
		set_config(20'h80000, 20'h80000, 20'h80000, 16'h8000, 16'h7FFF, 16'h8000,
			63'h7FFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE, {$urandom, $urandom});
		pending_pos.push_back(pos3(-524288, -524288, -524288));
		pending_pos.push_back(pos3(524287, 524287, 524287));
		pending_pos.push_back(pos3(-524287, -524288, -524288));
		pending_pos.push_back(pos3(0, 0, 0));
		queue_random(130);
		wait_idle();

		// Opposite corner with zero gain; the long hold-off fills the pipeline here.
		set_config(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, '0);
		hold_go = 1'b1;
		queue_random(130);
		wait_idle();

		send_idle = 78;
		recv_idle = 32;
		for (int p = 0; p < 2; p++) begin
			set_config(CB'($urandom), CB'($urandom), CB'($urandom), rand_moment(),
				rand_moment(), rand_moment(), rand_gain());
			queue_random(150);
			wait_idle();
		end

		send_idle = 0;
		recv_idle = 0;
		for (int p = 0; p < 2; p++) begin
			set_config(CB'($urandom), CB'($urandom), CB'($urandom), rand_moment(),
				rand_moment(), rand_moment(), rand_gain());
			queue_random(150);
			wait_idle();
		end

		$display("Covered %0d sensor items over eight register settings; %0d fields saturated,",
			n_items, n_sat);
		$display("%0d sensors sat on the magnet, %0d result items checked.", n_at_magnet,
			n_results);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
